### hw/rtl/vhtt_pkg.sv
// Shared types, constants and helper functions for the vote histogram block.
// Used by the front classifier, the command queue, the back end and the top.
`default_nettype none

package vhtt_pkg;

   // Sizing
   localparam int NUM_BINS    = 16;
   localparam int COUNT_BITS  = 16;
   localparam int BIN_BITS    = $clog2(NUM_BINS);
   localparam int NCNT_BITS   = BIN_BITS + 1;
   localparam int VOTE_BITS   = 5;
   localparam int CAND_BITS   = 5;
   localparam int OUT_BITS    = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = PTR_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Classified vote travelling from the front to the back
   typedef struct packed {
      logic                 is_valid;
      logic [BIN_BITS-1:0]  bin;
      logic                 last;
      logic [NCNT_BITS-1:0] ncand;
   } cmd_type;

   // Election result
   typedef struct packed {
      logic [CAND_BITS-1:0] winner;
      logic [OUT_BITS-1:0]  winner_votes;
      logic [CAND_BITS-1:0] runner_up;
      logic [OUT_BITS-1:0]  runner_votes;
      logic [OUT_BITS-1:0]  margin;
      logic [OUT_BITS-1:0]  total_votes;
      logic [OUT_BITS-1:0]  invalid_votes;
   } rsp_type;

   // Saturating increment of a counter
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
   endfunction

   // Clip a count to the 16-bit report width
   function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
      if ((COUNT_BITS > OUT_BITS) && (v > COUNT_BITS'(17'h0FFFF)))
         clip_out = {OUT_BITS{1'b1}};
      else
         clip_out = OUT_BITS'(v);
   endfunction

   // Zero-based bin index to 1-based candidate number
   function automatic logic [CAND_BITS-1:0] to_cand(input logic [BIN_BITS-1:0] idx);
      logic [NCNT_BITS-1:0] t;
      t = NCNT_BITS'(idx) + NCNT_BITS'(1);
      to_cand = CAND_BITS'(t);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/vhtt_front.sv
// Front end: holds the candidate-count register and classifies each vote.
// Depends on vhtt_pkg; feeds vhtt_queue.
`default_nettype none

module vhtt_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [4:0]                     csr_write_data,
   input  wire logic                           req_valid,
   input  wire logic [vhtt_pkg::VOTE_BITS-1:0] req_vote,
   input  wire logic                           req_last,
   input  wire logic                           q_full,
   output logic                                req_stall,
   output logic                                q_push,
   output vhtt_pkg::cmd_type                   q_cmd
);
   import vhtt_pkg::*;

   localparam int CMP_BITS = (NCNT_BITS > VOTE_BITS) ? NCNT_BITS : VOTE_BITS;

   logic [4:0]           ncand_ff;
   logic [NCNT_BITS-1:0] ncand_eff;
   logic [CMP_BITS-1:0]  vote_ext;
   logic [BIN_BITS-1:0]  vote_m1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ncand_ff <= 5'd16;
      end else if (csr_write_en) begin
         ncand_ff <= csr_write_data;
      end
   end

   // Clamp register to 1..NUM_BINS
   always_comb begin
      if (ncand_ff == 5'd0)
         ncand_eff = NCNT_BITS'(1);
      else if (CMP_BITS'(ncand_ff) > CMP_BITS'(NUM_BINS))
         ncand_eff = NCNT_BITS'(NUM_BINS);
      else
         ncand_eff = NCNT_BITS'(ncand_ff);
   end

   // Classify the vote
   assign vote_ext = CMP_BITS'(req_vote);
   assign vote_m1  = BIN_BITS'(req_vote - VOTE_BITS'(1));

   always_comb begin
      q_cmd.is_valid = (req_vote != '0) && (vote_ext <= CMP_BITS'(ncand_eff));
      q_cmd.bin      = vote_m1;
      q_cmd.last     = req_last;
      q_cmd.ncand    = ncand_eff;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

### hw/rtl/vhtt_queue.sv
// Short command queue between the front classifier and the back end.
// Depends on vhtt_pkg for the command type and depth.
`default_nettype none

module vhtt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire vhtt_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output vhtt_pkg::cmd_type      head_cmd,
   output logic                   full,
   output logic                   empty
);
   import vhtt_pkg::*;

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff;
   logic [PTR_BITS-1:0]  rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + QCNT_BITS'(1);
            2'b01:   count_ff <= count_ff - QCNT_BITS'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vhtt_back.sv
// Back end: bin counters, totals, end-of-election top-two scan and result register.
// Depends on vhtt_pkg; pulls commands from vhtt_queue.
`default_nettype none

module vhtt_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire vhtt_pkg::cmd_type q_cmd,
   input  wire logic              q_empty,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output vhtt_pkg::rsp_type      rsp
);
   import vhtt_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_SCAN,
      ST_OUT
   } state_type;

   state_type             state_ff;
   logic [COUNT_BITS-1:0] bin_ff [NUM_BINS];
   logic [COUNT_BITS-1:0] valid_tot_ff;
   logic [COUNT_BITS-1:0] invalid_tot_ff;
   logic [BIN_BITS-1:0]   scan_idx_ff;
   logic [NCNT_BITS-1:0]  scan_n_ff;
   logic [BIN_BITS-1:0]   win_ff;
   logic [COUNT_BITS-1:0] win_cnt_ff;
   logic [BIN_BITS-1:0]   run_ff;
   logic [COUNT_BITS-1:0] run_cnt_ff;
   logic                  have_run_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [COUNT_BITS-1:0] scan_cnt;
   logic                  scan_in_range;
   logic                  out_free;
   logic [COUNT_BITS-1:0] run_cnt_eff;

   assign q_pop         = (state_ff == ST_RUN) && !q_empty;
   assign scan_cnt      = bin_ff[scan_idx_ff];
   assign scan_in_range = {1'b0, scan_idx_ff} < scan_n_ff;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign run_cnt_eff   = have_run_ff ? run_cnt_ff : '0;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;

   // Bin counters: increment on a valid vote, cleared bin by bin during the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) bin_ff[i] <= '0;
      end else if (q_pop && q_cmd.is_valid) begin
         bin_ff[q_cmd.bin] <= sat_inc(bin_ff[q_cmd.bin]);
      end else if (state_ff == ST_SCAN) begin
         bin_ff[scan_idx_ff] <= '0;
      end
   end

   // Control, totals, top-two tracking and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_RUN;
         valid_tot_ff   <= '0;
         invalid_tot_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         scan_idx_ff    <= '0;
         scan_n_ff      <= '0;
         have_run_ff    <= 1'b0;
      end else begin
         // Result taken; ST_OUT handles its own load
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_RUN: begin
               if (q_pop) begin
                  if (q_cmd.is_valid) valid_tot_ff <= sat_inc(valid_tot_ff);
                  else                invalid_tot_ff <= sat_inc(invalid_tot_ff);
                  if (q_cmd.last) begin
                     state_ff    <= ST_SCAN;
                     scan_idx_ff <= '0;
                     scan_n_ff   <= q_cmd.ncand;
                     have_run_ff <= 1'b0;
                  end
               end
            end
            ST_SCAN: begin
               // One bin per cycle; the first bin always seeds the winner
               if (scan_idx_ff == '0) begin
                  win_ff     <= scan_idx_ff;
                  win_cnt_ff <= scan_cnt;
               end else if (scan_in_range) begin
                  if (scan_cnt > win_cnt_ff) begin
                     win_ff      <= scan_idx_ff;
                     win_cnt_ff  <= scan_cnt;
                     run_ff      <= win_ff;
                     run_cnt_ff  <= win_cnt_ff;
                     have_run_ff <= 1'b1;
                  end else if (!have_run_ff || scan_cnt > run_cnt_ff) begin
                     run_ff      <= scan_idx_ff;
                     run_cnt_ff  <= scan_cnt;
                     have_run_ff <= 1'b1;
                  end
               end
               if (scan_idx_ff == BIN_BITS'(NUM_BINS - 1)) state_ff <= ST_OUT;
               else scan_idx_ff <= scan_idx_ff + BIN_BITS'(1);
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.winner        <= to_cand(win_ff);
                  rsp_ff.winner_votes  <= clip_out(win_cnt_ff);
                  rsp_ff.runner_up     <= have_run_ff ? to_cand(run_ff) : '0;
                  rsp_ff.runner_votes  <= clip_out(run_cnt_eff);
                  rsp_ff.margin        <= clip_out(win_cnt_ff - run_cnt_eff);
                  rsp_ff.total_votes   <= clip_out(valid_tot_ff);
                  rsp_ff.invalid_votes <= clip_out(invalid_tot_ff);
                  valid_tot_ff         <= '0;
                  invalid_tot_ff       <= '0;
                  state_ff             <= ST_RUN;
               end
            end
            default: state_ff <= ST_RUN;
         endcase
      end
   end

endmodule

`default_nettype wire

### hw/rtl/vote_histogram_top_two.sv
// Top level of the vote histogram with top-two selection.
// Depends on vhtt_pkg, vhtt_front, vhtt_queue and vhtt_back.
`default_nettype none

// Votes are taken at one per cycle while the queue is not full: each is
// classified on entry against csr num_candidates and queued, and the back end
// adds it to its bin when it pops it. A vote marked last is counted, then the
// back end walks all NUM_BINS bins one per cycle (finding winner and runner-up
// and clearing each bin), and loads the result register in ST_OUT once the
// result output is free. The front keeps accepting into the four-entry queue
// during the scan until it fills.
module vote_histogram_top_two (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [4:0]                     csr_write_data,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [vhtt_pkg::VOTE_BITS-1:0] req_vote,
   input  wire logic                           req_last,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [vhtt_pkg::CAND_BITS-1:0]      rsp_winner,
   output logic [vhtt_pkg::OUT_BITS-1:0]       rsp_winner_votes,
   output logic [vhtt_pkg::CAND_BITS-1:0]      rsp_runner_up,
   output logic [vhtt_pkg::OUT_BITS-1:0]       rsp_runner_votes,
   output logic [vhtt_pkg::OUT_BITS-1:0]       rsp_margin,
   output logic [vhtt_pkg::OUT_BITS-1:0]       rsp_total_votes,
   output logic [vhtt_pkg::OUT_BITS-1:0]       rsp_invalid_votes
);
   import vhtt_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   rsp_type rsp;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   // Classifier and configuration register
   vhtt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_vote       (req_vote),
      .req_last       (req_last),
      .q_full         (q_full),
      .req_stall      (req_stall),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   // Command queue
   vhtt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Histogram and scan
   vhtt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_cmd     (head_cmd),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_winner        = rsp.winner;
   assign rsp_winner_votes  = rsp.winner_votes;
   assign rsp_runner_up     = rsp.runner_up;
   assign rsp_runner_votes  = rsp.runner_votes;
   assign rsp_margin        = rsp.margin;
   assign rsp_total_votes   = rsp.total_votes;
   assign rsp_invalid_votes = rsp.invalid_votes;

endmodule

`default_nettype wire
